@@ src/hsvc_pkg.sv @@
// hsvc_pkg: shared constants, sector codes and the queue item type of the hsv to rgb converter
// no dependencies; used by every other file of the block

package hsvc_pkg;

   // fixed point formats
   localparam int UNIT_BITS     = 12;
   localparam int HUE_FRAC_BITS = 6;

   // field widths
   localparam int HUE_W   = 15;
   localparam int COLOR_W = 13;

   // derived constants
   localparam int UNIT     = 1 << UNIT_BITS;
   localparam int W60      = 60 << HUE_FRAC_BITS;
   localparam int HUE_MAX  = 360 << HUE_FRAC_BITS;
   localparam int WEIGHT_W = $clog2(W60 + 1);
   localparam int PROD_W   = 2 * COLOR_W;

   // w60 = 15 * 2^(HUE_FRAC_BITS+2): shift first, then divide by fifteen
   localparam int W60_SHIFT = HUE_FRAC_BITS + 2;
   localparam int SCALED_W  = COLOR_W + 4;
   localparam int RECIP_15  = (1 << SCALED_W) / 15;
   localparam int RECIP_W   = $clog2(RECIP_15 + 1);

   // decoupling queue
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // 60-degree sectors
   localparam logic [2:0] SECT_RED_YELLOW   = 3'd0;
   localparam logic [2:0] SECT_YELLOW_GREEN = 3'd1;
   localparam logic [2:0] SECT_GREEN_CYAN   = 3'd2;
   localparam logic [2:0] SECT_CYAN_BLUE    = 3'd3;
   localparam logic [2:0] SECT_BLUE_MAGENTA = 3'd4;
   localparam logic [2:0] SECT_MAGENTA_RED  = 3'd5;

   typedef struct packed {
      logic                range_error;
      logic [2:0]          sector;
      logic [COLOR_W-1:0]  chroma;
      logic [COLOR_W-1:0]  brightness;
      logic [WEIGHT_W-1:0] weight;
   } item_type;

endpackage

@@ src/hsvc_if.sv @@
// hsvc_if: valid/ready channel interfaces for hsv items in and rgb items out
// depends on hsvc_pkg for field widths

interface hsvc_req_if;
   logic                        valid;
   logic                        ready;
   logic [hsvc_pkg::HUE_W-1:0]   hue;
   logic [hsvc_pkg::COLOR_W-1:0] saturation;
   logic [hsvc_pkg::COLOR_W-1:0] brightness;

   modport source (output valid, hue, saturation, brightness, input ready);
   modport sink (input valid, hue, saturation, brightness, output ready);
endinterface

interface hsvc_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [hsvc_pkg::COLOR_W-1:0] red;
   logic [hsvc_pkg::COLOR_W-1:0] green;
   logic [hsvc_pkg::COLOR_W-1:0] blue;
   logic                        range_error;

   modport source (output valid, red, green, blue, range_error, input ready);
   modport sink (input valid, red, green, blue, range_error, output ready);
endinterface

@@ src/hsvc_front.sv @@
// hsvc_front: range check, sector and window weight of the hue, chroma product
// depends on hsvc_pkg

module hsvc_front (
   input  logic [hsvc_pkg::HUE_W-1:0]   hue,
   input  logic [hsvc_pkg::COLOR_W-1:0] saturation,
   input  logic [hsvc_pkg::COLOR_W-1:0] brightness,
   output hsvc_pkg::item_type           item
);

   logic [31:0]                   hue_ext;
   logic [2:0]                    sector;
   logic [31:0]                   base;
   logic [31:0]                   pos;
   logic [31:0]                   win_dist;
   logic [hsvc_pkg::PROD_W-1:0]    sv_prod;

   assign hue_ext = 32'(hue);

   // sector index: count of 60-degree boundaries passed, hue of 360 stays in the last
   always_comb begin
      sector = 3'd0;
      for (int k = 1; k <= 5; k++) begin
         sector = sector + 3'(hue_ext >= 32'(k * hsvc_pkg::W60));
      end
   end

   // start of the 120-degree window
   always_comb begin
      unique case (sector)
         hsvc_pkg::SECT_RED_YELLOW, hsvc_pkg::SECT_YELLOW_GREEN: base = 32'd0;
         hsvc_pkg::SECT_GREEN_CYAN, hsvc_pkg::SECT_CYAN_BLUE: base = 32'(2 * hsvc_pkg::W60);
         default: base = 32'(4 * hsvc_pkg::W60);
      endcase
   end

   assign pos      = hue_ext - base;
   assign win_dist = (pos >= 32'(hsvc_pkg::W60)) ? (pos - 32'(hsvc_pkg::W60))
                                                 : (32'(hsvc_pkg::W60) - pos);

   assign sv_prod = hsvc_pkg::PROD_W'(saturation) * hsvc_pkg::PROD_W'(brightness);

   assign item.range_error = (hue_ext > 32'(hsvc_pkg::HUE_MAX))
                           || (32'(saturation) > 32'(hsvc_pkg::UNIT))
                           || (32'(brightness) > 32'(hsvc_pkg::UNIT));
   assign item.sector      = sector;
   assign item.chroma      = hsvc_pkg::COLOR_W'(sv_prod >> hsvc_pkg::UNIT_BITS);
   assign item.brightness  = brightness;
   assign item.weight      = hsvc_pkg::WEIGHT_W'(32'(hsvc_pkg::W60) - win_dist);

endmodule

@@ src/hsvc_queue.sv @@
// hsvc_queue: short fifo of classified items between front and back
// depends on hsvc_pkg

module hsvc_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  hsvc_pkg::item_type push_item,
   output logic               full,
   input  logic               pop,
   output logic               not_empty,
   output hsvc_pkg::item_type pop_item
);

   hsvc_pkg::item_type              mem_ff [hsvc_pkg::QUEUE_DEPTH];
   logic [hsvc_pkg::QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [hsvc_pkg::QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [hsvc_pkg::QCNT_W-1:0]     count_ff, count_in;

   assign full      = (count_ff == hsvc_pkg::QCNT_W'(hsvc_pkg::QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_item  = mem_ff[rd_ptr_ff];

   function automatic logic [hsvc_pkg::QPTR_W-1:0] next_ptr(
      input logic [hsvc_pkg::QPTR_W-1:0] ptr);
      if (32'(ptr) == hsvc_pkg::QUEUE_DEPTH - 1) begin
         return '0;
      end
      return ptr + 1'b1;
   endfunction

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + hsvc_pkg::QCNT_W'(push) - hsvc_pkg::QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!full || pop))
      else $error("queue push while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("queue pop while empty");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= hsvc_pkg::QUEUE_DEPTH)
      else $error("queue count beyond depth");

endmodule

@@ src/hsvc_back.sv @@
// hsvc_back: three-stage pipeline computing x, ordering c, x and 0, adding m
// depends on hsvc_pkg and hsvc_rsp_if

module hsvc_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  hsvc_pkg::item_type in_item,
   output logic               in_pop,
   hsvc_rsp_if.source         rsp
);

   logic advance;

   // stage 1: c times window weight, scaled down by 4 * 2^frac
   logic                          s1_valid_ff;
   logic                          s1_err_ff;
   logic [2:0]                    s1_sector_ff;
   logic [hsvc_pkg::COLOR_W-1:0]  s1_chroma_ff;
   logic [hsvc_pkg::COLOR_W-1:0]  s1_offset_ff;
   logic [hsvc_pkg::SCALED_W-1:0] s1_scaled_ff;
   logic [hsvc_pkg::COLOR_W+hsvc_pkg::WEIGHT_W-1:0] cw_prod;

   // stage 2: reciprocal estimate of the divide by fifteen
   logic                          s2_valid_ff;
   logic                          s2_err_ff;
   logic [2:0]                    s2_sector_ff;
   logic [hsvc_pkg::COLOR_W-1:0]  s2_chroma_ff;
   logic [hsvc_pkg::COLOR_W-1:0]  s2_offset_ff;
   logic [hsvc_pkg::SCALED_W-1:0] s2_scaled_ff;
   logic [hsvc_pkg::SCALED_W-1:0] s2_quot_ff;
   logic [hsvc_pkg::SCALED_W+hsvc_pkg::RECIP_W-1:0] recip_prod;

   // stage 3: correction, ordering, offset
   logic [hsvc_pkg::SCALED_W-1:0] rem;
   logic [hsvc_pkg::COLOR_W-1:0]  x_val;
   logic [hsvc_pkg::COLOR_W-1:0]  r_raw, g_raw, b_raw;
   logic                          out_valid_ff;
   logic [hsvc_pkg::COLOR_W-1:0]  red_ff, green_ff, blue_ff;
   logic                          err_ff;

   assign advance = !out_valid_ff || rsp.ready;
   assign in_pop  = advance && in_valid;

   assign cw_prod = (hsvc_pkg::COLOR_W + hsvc_pkg::WEIGHT_W)'(in_item.chroma)
                  * (hsvc_pkg::COLOR_W + hsvc_pkg::WEIGHT_W)'(in_item.weight);

   assign recip_prod = (hsvc_pkg::SCALED_W + hsvc_pkg::RECIP_W)'(s1_scaled_ff)
                     * (hsvc_pkg::SCALED_W + hsvc_pkg::RECIP_W)'(hsvc_pkg::RECIP_15);

   // estimate is exact or one low
   assign rem   = s2_scaled_ff - ((s2_quot_ff << 4) - s2_quot_ff);
   assign x_val = hsvc_pkg::COLOR_W'(s2_quot_ff)
                + hsvc_pkg::COLOR_W'(rem >= hsvc_pkg::SCALED_W'(15));

   always_comb begin
      unique case (s2_sector_ff)
         hsvc_pkg::SECT_RED_YELLOW: begin
            r_raw = s2_chroma_ff; g_raw = x_val;        b_raw = '0;
         end
         hsvc_pkg::SECT_YELLOW_GREEN: begin
            r_raw = x_val;        g_raw = s2_chroma_ff; b_raw = '0;
         end
         hsvc_pkg::SECT_GREEN_CYAN: begin
            r_raw = '0;           g_raw = s2_chroma_ff; b_raw = x_val;
         end
         hsvc_pkg::SECT_CYAN_BLUE: begin
            r_raw = '0;           g_raw = x_val;        b_raw = s2_chroma_ff;
         end
         hsvc_pkg::SECT_BLUE_MAGENTA: begin
            r_raw = x_val;        g_raw = '0;           b_raw = s2_chroma_ff;
         end
         default: begin
            r_raw = s2_chroma_ff; g_raw = '0;           b_raw = x_val;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_err_ff    <= in_item.range_error;
         s1_sector_ff <= in_item.sector;
         s1_chroma_ff <= in_item.chroma;
         s1_offset_ff <= in_item.brightness - in_item.chroma;
         s1_scaled_ff <= hsvc_pkg::SCALED_W'(cw_prod >> hsvc_pkg::W60_SHIFT);

         s2_err_ff    <= s1_err_ff;
         s2_sector_ff <= s1_sector_ff;
         s2_chroma_ff <= s1_chroma_ff;
         s2_offset_ff <= s1_offset_ff;
         s2_scaled_ff <= s1_scaled_ff;
         s2_quot_ff   <= hsvc_pkg::SCALED_W'(recip_prod >> hsvc_pkg::SCALED_W);

         err_ff   <= s2_err_ff;
         red_ff   <= s2_err_ff ? '0 : r_raw + s2_offset_ff;
         green_ff <= s2_err_ff ? '0 : g_raw + s2_offset_ff;
         blue_ff  <= s2_err_ff ? '0 : b_raw + s2_offset_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= in_valid;
         s2_valid_ff  <= s1_valid_ff;
         out_valid_ff <= s2_valid_ff;
      end
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.red         = red_ff;
   assign rsp.green       = green_ff;
   assign rsp.blue        = blue_ff;
   assign rsp.range_error = err_ff;

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && err_ff) |-> (red_ff == '0 && green_ff == '0 && blue_ff == '0))
      else $error("range error item carries nonzero color");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp.ready) |=> ($stable(s1_valid_ff) && $stable(s2_valid_ff)))
      else $error("pipeline moved during output stall");

   a_pop_on_advance: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp.ready) |-> !in_pop)
      else $error("queue popped during output stall");

endmodule

@@ src/hsv_to_rgb_converter.sv @@
// hsv_to_rgb_converter: top level, hsv pixel in, rgb pixel out
// depends on hsvc_pkg, hsvc_if, hsvc_front, hsvc_queue, hsvc_back
//
//   channel | dir | handshake       | payload
//   req     | in  | valid / ready   | hue, saturation, brightness
//   rsp     | out | valid / ready   | red, green, blue, range_error
//
// one item per clock sustained while rsp.ready is high; path: queue, s1, s2, output register
// one item per cycle: front combinational, each back stage takes a new item each unstalled cycle
// reset is synchronous and active high; it empties the queue and the pipeline
// req.ready drops whenever the two-entry queue is full, even in a cycle that drains it
// an output stall freezes the back pipeline; the queue absorbs two more items
// after a stall ends, req.ready returns in the cycle after the first rsp item leaves

module hsv_to_rgb_converter (
   input  logic        clock,
   input  logic        reset,
   hsvc_req_if.sink    req,
   hsvc_rsp_if.source  rsp
);

   // classified item from the front, straight into the queue
   hsvc_pkg::item_type front_item;
   hsvc_pkg::item_type queue_item;
   logic               queue_full;
   logic               queue_not_empty;
   logic               queue_pop;
   logic               queue_push;

   // item accepted whenever the queue has room
   assign req.ready  = !queue_full;
   assign queue_push = req.valid && !queue_full;

   // range check, sector, window weight and chroma product
   hsvc_front u_front (
      .hue        (req.hue),
      .saturation (req.saturation),
      .brightness (req.brightness),
      .item       (front_item)
   );

   // decoupling between acceptance and computation
   hsvc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (queue_push),
      .push_item (front_item),
      .full      (queue_full),
      .pop       (queue_pop),
      .not_empty (queue_not_empty),
      .pop_item  (queue_item)
   );

   // x computation, color ordering and offset, output register
   hsvc_back u_back (
      .clock    (clock),
      .reset    (reset),
      .in_valid (queue_not_empty),
      .in_item  (queue_item),
      .in_pop   (queue_pop),
      .rsp      (rsp)
   );

endmodule

@@ tb/sv/testbench.sv @@
// testbench: self-checking bench for hsv_to_rgb_converter, directed and random pixels
// depends on hsvc_pkg, hsvc_if and the converter rtl; needs nothing else

module testbench;

   // run limits
   localparam int CYCLE_LIMIT   = 200000;
   localparam int STREAM_PIXELS = 1000;
   localparam int HOLD_CYCLES   = 200;
   localparam int DRAIN_CYCLES  = 20;
   localparam int MAX_REPORTS   = 10;

   typedef logic [hsvc_pkg::HUE_W-1:0]   hue_type;
   typedef logic [hsvc_pkg::COLOR_W-1:0] comp_type;

   // one predicted rgb pixel, with the hsv item it came from for reporting
   typedef struct {
      hue_type  hue;
      comp_type saturation;
      comp_type brightness;
      comp_type red;
      comp_type green;
      comp_type blue;
      logic     range_error;
   } rgb_pixel_type;

   // how the rgb side takes results when it is not in a long hold
   typedef enum {RX_ALWAYS, RX_RANDOM, RX_PATTERN} stall_mode_type;

   logic clock;
   logic reset;

   hsvc_req_if req_ch ();
   hsvc_rsp_if rsp_ch ();

   hsv_to_rgb_converter i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   // expected rgb pixels, oldest first
   rgb_pixel_type pixel_expect_q[$];

   int             cycle_count    = 0;
   int             pixels_sent    = 0;
   int             pixels_checked = 0;
   int             range_errors   = 0;
   int             mismatches     = 0;
   int             unexpected     = 0;
   stall_mode_type stall_mode     = RX_ALWAYS;
   int             hold_requests  = 0;

   // free-running clock, period 20
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // hsv to rgb in fixed point: chroma, offset, ramp value, then sector order
   function automatic rgb_pixel_type predict_rgb(hue_type h, comp_type s, comp_type v);
      rgb_pixel_type px;
      int unsigned   chroma;
      int unsigned   offset;
      int unsigned   ramp;
      int unsigned   pos;
      int unsigned   win_dist;
      int unsigned   sect;
      int unsigned   r;
      int unsigned   g;
      int unsigned   b;
      px.hue         = h;
      px.saturation  = s;
      px.brightness  = v;
      px.red         = '0;
      px.green       = '0;
      px.blue        = '0;
      px.range_error = 1'b0;
      // out of range hue, saturation or brightness: flag and zero colour
      if (h > hsvc_pkg::HUE_MAX || s > hsvc_pkg::UNIT || v > hsvc_pkg::UNIT) begin
         px.range_error = 1'b1;
         return px;
      end
      chroma   = (int'(s) * int'(v)) >> hsvc_pkg::UNIT_BITS;
      offset   = int'(v) - chroma;
      // distance from the centre of the 120-degree window
      pos      = int'(h) % (2 * hsvc_pkg::W60);
      win_dist = (pos >= hsvc_pkg::W60) ? pos - hsvc_pkg::W60 : hsvc_pkg::W60 - pos;
      ramp     = (chroma * (hsvc_pkg::W60 - win_dist)) / hsvc_pkg::W60;
      // hue of exactly 360 stays in the magenta-red sector
      sect     = int'(h) / hsvc_pkg::W60;
      if (sect > hsvc_pkg::SECT_MAGENTA_RED)
         sect = hsvc_pkg::SECT_MAGENTA_RED;
      case (sect[2:0])
         hsvc_pkg::SECT_RED_YELLOW: begin
            r = chroma; g = ramp; b = 0;
         end
         hsvc_pkg::SECT_YELLOW_GREEN: begin
            r = ramp; g = chroma; b = 0;
         end
         hsvc_pkg::SECT_GREEN_CYAN: begin
            r = 0; g = chroma; b = ramp;
         end
         hsvc_pkg::SECT_CYAN_BLUE: begin
            r = 0; g = ramp; b = chroma;
         end
         hsvc_pkg::SECT_BLUE_MAGENTA: begin
            r = ramp; g = 0; b = chroma;
         end
         default: begin
            r = chroma; g = 0; b = ramp;
         end
      endcase
      px.red   = comp_type'(r + offset);
      px.green = comp_type'(g + offset);
      px.blue  = comp_type'(b + offset);
      return px;
   endfunction

   // rgb side: long holds on request, otherwise the current stall mode
   initial begin
      int         hold_served;
      int         hold_left;
      logic [7:0] stall_pattern;
      hold_served   = 0;
      hold_left     = 0;
      stall_pattern = 8'b1101_0110;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            case (stall_mode)
               RX_ALWAYS: rsp_ch.ready <= 1'b1;
               RX_RANDOM: rsp_ch.ready <= ($urandom_range(0, 99) < 65);
               default: begin
                  stall_pattern = {stall_pattern[6:0], stall_pattern[7]};
                  rsp_ch.ready <= stall_pattern[0];
               end
            endcase
         end
      end
   end

   // monitor: predict every accepted hsv item, check every accepted rgb item
   always @(posedge clock) begin
      rgb_pixel_type want;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            want = predict_rgb(req_ch.hue, req_ch.saturation, req_ch.brightness);
            pixel_expect_q.insert(pixel_expect_q.size(), want);
            pixels_sent++;
            if (want.range_error)
               range_errors++;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (pixel_expect_q.size() == 0) begin
               unexpected++;
               if (unexpected + mismatches <= MAX_REPORTS)
                  $display("unexpected rgb item r=%0d g=%0d b=%0d err=%0b",
                           rsp_ch.red, rsp_ch.green, rsp_ch.blue, rsp_ch.range_error);
            end else begin
               want = pixel_expect_q.pop_front();
               pixels_checked++;
               if (rsp_ch.red !== want.red || rsp_ch.green !== want.green ||
                   rsp_ch.blue !== want.blue || rsp_ch.range_error !== want.range_error)
               begin
                  mismatches++;
                  if (unexpected + mismatches <= MAX_REPORTS)
                     $display("mismatch h=%0d s=%0d v=%0d want %0d/%0d/%0d/%0b got %0d/%0d/%0d/%0b",
                              want.hue, want.saturation, want.brightness,
                              want.red, want.green, want.blue, want.range_error,
                              rsp_ch.red, rsp_ch.green, rsp_ch.blue, rsp_ch.range_error);
               end
            end
         end
      end
   end

   // watchdog on the whole run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d rgb items still due",
                  cycle_count, pixel_expect_q.size());
         $display("hsv_to_rgb_converter verification failed");
         $finish;
      end
   end

   // offer one hsv item and hold it until the converter takes it
   task automatic send_pixel(input hue_type h, input comp_type s, input comp_type v);
      req_ch.valid      <= 1'b1;
      req_ch.hue        <= h;
      req_ch.saturation <= s;
      req_ch.brightness <= v;
      do
         @(posedge clock);
      while (req_ch.ready !== 1'b1);
   endtask

   // drop valid for a number of cycles; zero keeps the burst going
   task automatic pause_sender(input int cycles);
      if (cycles > 0) begin
         req_ch.valid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      while (pixel_expect_q.size() != 0)
         @(posedge clock);
   endtask

   // sector boundaries, window centres and hue 360, mostly at full saturation and value
   task automatic test_sector_edges();
      comp_type full;
      full = comp_type'(hsvc_pkg::UNIT);
      send_pixel(hue_type'(0), full, full);
      send_pixel(hue_type'(hsvc_pkg::W60 / 2), full, full);
      send_pixel(hue_type'(hsvc_pkg::W60 - 1), full, full);
      for (int k = 1; k <= 5; k++)
         send_pixel(hue_type'(k * hsvc_pkg::W60), full, full);
      send_pixel(hue_type'(hsvc_pkg::HUE_MAX - 1), full, full);
      send_pixel(hue_type'(hsvc_pkg::HUE_MAX), full, full);
      send_pixel(hue_type'(hsvc_pkg::W60 + hsvc_pkg::W60 / 2), full,
                 comp_type'(hsvc_pkg::UNIT / 2));
      pause_sender(4);
   endtask

   // out of range fields, zero fields and truncation of tiny products
   task automatic test_range_limits();
      comp_type full;
      hue_type  w60;
      full = comp_type'(hsvc_pkg::UNIT);
      w60  = hue_type'(hsvc_pkg::W60);
      send_pixel(hue_type'(hsvc_pkg::HUE_MAX + 1), full, full);
      send_pixel('1, full, full);
      send_pixel(w60, comp_type'(hsvc_pkg::UNIT + 1), full);
      send_pixel(w60, '1, full);
      send_pixel(w60, full, comp_type'(hsvc_pkg::UNIT + 1));
      send_pixel(w60, full, '1);
      send_pixel(hue_type'(0), comp_type'(0), comp_type'(0));
      send_pixel(hue_type'(2 * hsvc_pkg::W60), comp_type'(0), full);
      send_pixel(hue_type'(3 * hsvc_pkg::W60), full, comp_type'(0));
      send_pixel(hue_type'(1), comp_type'(1), comp_type'(1));
      send_pixel(hue_type'(hsvc_pkg::W60 + 7), comp_type'(hsvc_pkg::UNIT - 1),
                 comp_type'(hsvc_pkg::UNIT - 1));
      pause_sender(3);
   endtask

   // random hsv item: mostly in range, some near sector edges, some noise
   task automatic random_pixel(output hue_type h, output comp_type s, output comp_type v);
      int unsigned edge_hue;
      case ($urandom_range(0, 9))
         0: begin
            // noise over the whole field widths, mostly range errors
            h = hue_type'($urandom_range(0, (1 << hsvc_pkg::HUE_W) - 1));
            s = comp_type'($urandom_range(0, (1 << hsvc_pkg::COLOR_W) - 1));
            v = comp_type'($urandom_range(0, (1 << hsvc_pkg::COLOR_W) - 1));
         end
         1: begin
            // one step either side of a sector boundary
            edge_hue = $urandom_range(0, 6) * hsvc_pkg::W60 + $urandom_range(0, 2);
            edge_hue = (edge_hue == 0) ? 0 : edge_hue - 1;
            if (edge_hue > hsvc_pkg::HUE_MAX + 1)
               edge_hue = hsvc_pkg::HUE_MAX + 1;
            h = hue_type'(edge_hue);
            s = comp_type'($urandom_range(0, hsvc_pkg::UNIT));
            v = comp_type'($urandom_range(0, hsvc_pkg::UNIT));
         end
         2: begin
            // saturation at a limit, value at full or random in range
            h = hue_type'($urandom_range(0, hsvc_pkg::HUE_MAX));
            s = $urandom_range(0, 1) ? comp_type'(hsvc_pkg::UNIT) : comp_type'(0);
            v = $urandom_range(0, 1) ? comp_type'(hsvc_pkg::UNIT)
                                     : comp_type'($urandom_range(0, hsvc_pkg::UNIT));
         end
         default: begin
            h = hue_type'($urandom_range(0, hsvc_pkg::HUE_MAX));
            s = comp_type'($urandom_range(0, hsvc_pkg::UNIT));
            v = comp_type'($urandom_range(0, hsvc_pkg::UNIT));
         end
      endcase
   endtask

   // long rgb hold while the hsv side keeps offering items back to back
   task automatic test_backpressure();
      hue_type  h;
      comp_type s;
      comp_type v;
      stall_mode = RX_ALWAYS;
      hold_requests++;
      for (int i = 0; i < 40; i++) begin
         random_pixel(h, s, v);
         send_pixel(h, s, v);
      end
      pause_sender(1);
      // hsv side stops until every rgb item is back
      wait_drained();
   endtask

   // random bursts and gaps against a changing rgb stall mode
   task automatic test_random_stream();
      hue_type  h;
      comp_type s;
      comp_type v;
      int       sent;
      int       burst;
      sent = 0;
      while (sent < STREAM_PIXELS) begin
         // change the rgb side behavior every so often
         if ($urandom_range(0, 7) == 0)
            stall_mode = stall_mode_type'($urandom_range(0, 2));
         burst = $urandom_range(1, 16);
         for (int i = 0; i < burst; i++) begin
            random_pixel(h, s, v);
            send_pixel(h, s, v);
            sent++;
         end
         // some stretches run with no gap at all
         if ($urandom_range(0, 3) != 0)
            pause_sender($urandom_range(1, 6));
      end
      pause_sender(1);
   endtask

   // main sequence
   initial begin
      reset             <= 1'b1;
      req_ch.valid      <= 1'b0;
      req_ch.hue        <= '0;
      req_ch.saturation <= '0;
      req_ch.brightness <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_sector_edges();
      test_range_limits();
      test_backpressure();
      test_random_stream();

      // let every rgb item come back, then watch for strays
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d hsv items sent (%0d out of range), %0d rgb items checked",
               pixels_sent, range_errors, pixels_checked);
      $display("sector edges, hue 360, range errors, long rgb hold and random stalls run");
      if (mismatches == 0 && unexpected == 0 && pixel_expect_q.size() == 0) begin
         $display("hsv_to_rgb_converter verification clean");
      end else begin
         $display("%0d mismatches, %0d unexpected, %0d missing",
                  mismatches, unexpected, pixel_expect_q.size());
         $display("hsv_to_rgb_converter verification failed");
      end
      $finish;
   end

endmodule

@@ hsv_to_rgb_converter.f @@
src/hsvc_pkg.sv
src/hsvc_if.sv
src/hsvc_front.sv
src/hsvc_queue.sv
src/hsvc_back.sv
src/hsv_to_rgb_converter.sv
tb/sv/testbench.sv
